>>> hw/rtl/mcb_pkg.sv
// mcb_pkg: shared types, constants and request codes for the mono canvas blitter
// used by mcb_ctrl, mcb_dpath and mono_canvas_blitter; no dependencies
package mcb_pkg;

    // store size default and clamp on canvas dimensions
    localparam int CANVAS_BYTES_DEF = 8192;
    localparam int MAX_DIM          = 1024;

    // internal coordinate, byte column, stride and address widths
    localparam int CW       = 12;
    localparam int BC_W     = CW - 3;
    localparam int STRIDE_W = 8;
    localparam int ADDR_W   = CW + STRIDE_W;

    // colour codes
    localparam logic [2:0] COLOR_BLACK = 3'd0;
    localparam logic [7:0] WHITE_CODE  = 8'd7;

    // request codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_FILL    = 3'd1;
    localparam logic [2:0] CMD_BITMAP  = 3'd2;
    localparam logic [2:0] CMD_EXTRACT = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_OVERRIDE = 2'd2;

    // one captured request
    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  x_pos;
        logic [9:0]  y_pos;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [2:0]  pixel_color;
        logic [9:0]  row_index;
        logic [6:0]  byte_index;
        logic [7:0]  source_byte;
    } t_req;

    // controller to datapath commands
    typedef struct packed {
        logic cap;
        logic dec;
        logic adr;
        logic rd;
        logic mod;
        logic step_byte;
        logic step_row;
        logic sweep;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       clip_ok;
        logic       need_ok;
        logic       ext_ok;
        logic       bm_row_ok;
        logic       second_needed;
        logic       bc_last;
        logic       row_last;
        logic       first;
        logic       sweep_done;
    } t_dp_stat;

endpackage

>>> hw/rtl/mcb_ctrl.sv
// mcb_ctrl: request sequencer for the mono canvas blitter
// depends on mcb_pkg; drives mcb_dpath through t_dp_cmd
module mcb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  mcb_pkg::t_dp_stat i_stat,
    output mcb_pkg::t_dp_cmd  o_cmd
);
    import mcb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_DEC, S_CLR, S_ADR, S_RD, S_MOD, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_FIN;
                case (i_stat.cmd)
                    CMD_CLEAR:   if (i_stat.need_ok) n_state = S_CLR;
                    CMD_FILL:    if (i_stat.clip_ok) n_state = S_ADR;
                    CMD_BITMAP:  if (i_stat.clip_ok && i_stat.bm_row_ok) n_state = S_ADR;
                    CMD_EXTRACT: if (i_stat.ext_ok) n_state = S_ADR;
                    default:     n_state = S_FIN;
                endcase
            end
            S_CLR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) n_state = S_FIN;
            end
            S_ADR: begin
                o_cmd.adr = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod = 1'b1;
                n_state   = S_FIN;
                case (i_stat.cmd)
                    CMD_FILL: begin
                        if (!i_stat.bc_last) begin
                            o_cmd.step_byte = 1'b1;
                            n_state         = S_ADR;
                        end else if (!i_stat.row_last) begin
                            o_cmd.step_row = 1'b1;
                            n_state        = S_ADR;
                        end
                    end
                    CMD_BITMAP: begin
                        if (i_stat.first && i_stat.second_needed) begin
                            o_cmd.step_byte = 1'b1;
                            n_state         = S_ADR;
                        end
                    end
                    CMD_EXTRACT: begin
                        if (i_stat.first) begin
                            o_cmd.step_byte = 1'b1;
                            n_state         = S_ADR;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // one request at a time: no accept straight after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> !o_s_ready)
        else $error("request accepted while busy");

    // a result appears only on leaving the finish state
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish");

    // store access only for drawing and extract requests
    a_access_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADR |-> (i_stat.cmd == CMD_FILL || i_stat.cmd == CMD_BITMAP
                              || i_stat.cmd == CMD_EXTRACT))
        else $error("store access for wrong request");

    // no requests straight out of reset while the store is swept
    a_init_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_ready)
        else $error("request taken during clearing pass");
`endif

endmodule

>>> hw/rtl/mcb_dpath.sv
// mcb_dpath: canvas store, clipping, colour tracking and result registers
// depends on mcb_pkg; sequenced by mcb_ctrl
module mcb_dpath #(
    parameter int CANVAS_BYTES = mcb_pkg::CANVAS_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcb_pkg::t_req     i_req,
    input  logic [10:0]       i_cfg_width,
    input  logic [10:0]       i_cfg_height,
    input  logic [7:0]        i_cfg_override,
    input  mcb_pkg::t_dp_cmd  i_cmd,
    output mcb_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_data,
    output logic [2:0]        o_color,
    output logic              o_ok,
    output logic              o_touched
);
    import mcb_pkg::*;

    localparam int AW = $clog2(CANVAS_BYTES);
    localparam int SW = AW + 1;
    localparam logic [ADDR_W-1:0] STORE_END  = ADDR_W'(CANVAS_BYTES);
    localparam logic [SW-1:0]     SWEEP_FULL = SW'(CANVAS_BYTES);

    // canvas store
    logic [7:0] r_store [CANVAS_BYTES];
    logic [7:0] r_rdata;

    // request and walk registers
    t_req              r_req;
    logic [CW-1:0]     r_row, r_row_end, r_lo, r_hi;
    logic [BC_W-1:0]   r_bc, r_bc_end;
    logic              r_fill, r_on, r_first;
    logic [ADDR_W-1:0] r_addr;
    logic              r_addr_ok;
    logic [7:0]        r_b0, r_b1;
    logic              r_ok;
    logic [2:0]        r_color;
    logic [SW-1:0]     r_sweep_cnt, r_sweep_lim;

    // colour and touched state
    logic       r_cc_valid, r_mixed, r_touched;
    logic [2:0] r_cc;

    // output payload
    logic [7:0] r_o_data;
    logic [2:0] r_o_color;
    logic       r_o_ok, r_o_touched;

    // canvas geometry from configuration
    logic [CW-1:0]       eff_w, eff_h, stride_full;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   need;
    logic                need_ok;

    assign eff_w       = (i_cfg_width > 11'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg_width);
    assign eff_h       = (i_cfg_height > 11'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg_height);
    assign stride_full = (eff_w + CW'(7)) >> 3;
    assign stride      = stride_full[STRIDE_W-1:0];
    assign need        = ADDR_W'(stride) * ADDR_W'(eff_h);
    assign need_ok     = (need <= STORE_END);

    // clipping of the captured rectangle
    logic [CW-1:0] x, y, w, h, xw, yh, wc, hc, base, row_in, x_end;
    logic [CW-1:0] bm_hi_a, bm_hi, ext_cnt, ext_stride, row_abs;
    logic          clip_ok, ext_ok, bm_row_ok, full_black;

    assign x       = CW'(r_req.x_pos);
    assign y       = CW'(r_req.y_pos);
    assign w       = CW'(r_req.rect_width);
    assign h       = CW'(r_req.rect_height);
    assign row_in  = CW'(r_req.row_index);
    assign xw      = x + w;
    assign yh      = y + h;
    assign wc      = (xw > eff_w) ? (eff_w - x) : w;
    assign hc      = (yh > eff_h) ? (eff_h - y) : h;
    assign clip_ok = (x < eff_w) && (y < eff_h) && (wc != '0) && (hc != '0);
    assign base    = x + CW'({r_req.byte_index, 3'b000});
    assign x_end   = x + wc;
    assign bm_hi_a = base + CW'(8);
    assign bm_hi   = (bm_hi_a < x_end) ? bm_hi_a : x_end;
    assign row_abs = y + row_in;

    assign bm_row_ok  = (row_in < hc);
    assign ext_stride = (w + CW'(7)) >> 3;
    assign ext_ok     = (xw <= eff_w) && (yh <= eff_h) && (row_in < h)
                        && (CW'(r_req.byte_index) < ext_stride);
    assign full_black = (r_req.pixel_color == COLOR_BLACK) && (x == '0) && (y == '0)
                        && (wc >= eff_w) && (hc >= eff_h);
    assign ext_cnt    = w - CW'({r_req.byte_index, 3'b000});

    // colour chosen for a query
    logic [2:0] query_color;
    always_comb begin
        if (i_cfg_override <= WHITE_CODE) query_color = i_cfg_override[2:0];
        else if (!r_mixed && r_cc_valid)  query_color = r_cc;
        else                              query_color = r_req.pixel_color;
    end

    // merged store byte for fill and bitmap writes
    logic [7:0] new_byte;
    always_comb begin
        logic [CW-1:0] p;
        logic [CW-1:0] off;
        logic          we;
        new_byte = r_rdata;
        for (int j = 0; j < 8; j++) begin
            p   = {r_bc, 3'(j)};
            off = p - r_lo;
            we  = (p >= r_lo) && (p < r_hi)
                  && (r_fill || r_req.source_byte[3'd7 - off[2:0]]);
            if (we) new_byte[7-j] = r_on;
        end
    end

    // extracted byte from the two store bytes that hold it
    logic [15:0] ext_pair;
    logic [7:0]  ext_mask, ext_data;
    assign ext_pair = {r_b0, r_b1} << base[2:0];
    assign ext_mask = (ext_cnt >= CW'(8)) ? 8'hFF : ~(8'hFF >> ext_cnt[2:0]);
    assign ext_data = (r_req.command == CMD_EXTRACT && r_ok) ? (ext_pair[15:8] & ext_mask)
                                                             : 8'h00;

    // status towards the controller
    always_comb begin
        o_stat               = '0;
        o_stat.cmd           = r_req.command;
        o_stat.clip_ok       = clip_ok;
        o_stat.need_ok       = need_ok;
        o_stat.ext_ok        = ext_ok;
        o_stat.bm_row_ok     = bm_row_ok;
        o_stat.second_needed = (base[2:0] != 3'd0);
        o_stat.bc_last       = (r_bc == r_bc_end);
        o_stat.row_last      = (r_row == r_row_end);
        o_stat.first         = r_first;
        o_stat.sweep_done    = (r_sweep_cnt == r_sweep_lim);
    end

    // request capture, walk registers and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_req <= i_req;
        if (i_cmd.dec) begin
            r_fill    <= (r_req.command == CMD_FILL);
            r_on      <= (r_req.pixel_color != COLOR_BLACK);
            r_first   <= 1'b1;
            r_b0      <= 8'h00;
            r_b1      <= 8'h00;
            r_row_end <= y + hc - CW'(1);
            r_bc_end  <= BC_W'((x_end - CW'(1)) >> 3);
            if (r_req.command == CMD_FILL) begin
                r_row <= y;
                r_bc  <= BC_W'(x >> 3);
                r_lo  <= x;
                r_hi  <= x_end;
            end else begin
                r_row <= row_abs;
                r_bc  <= BC_W'(base >> 3);
                r_lo  <= base;
                r_hi  <= bm_hi;
            end
            case (r_req.command)
                CMD_CLEAR:   r_ok <= need_ok;
                CMD_FILL:    r_ok <= 1'b1;
                CMD_BITMAP:  r_ok <= 1'b1;
                CMD_EXTRACT: r_ok <= ext_ok;
                CMD_QUERY:   r_ok <= 1'b1;
                default:     r_ok <= 1'b0;
            endcase
            r_color <= (r_req.command == CMD_QUERY) ? query_color : 3'd0;
        end
        if (i_cmd.adr) begin
            r_addr    <= ADDR_W'(r_row) * ADDR_W'(stride) + ADDR_W'(r_bc);
        end
        if (i_cmd.adr) r_addr_ok <= (ADDR_W'(r_row) * ADDR_W'(stride) + ADDR_W'(r_bc))
                                    < STORE_END;
        if (i_cmd.mod && r_req.command == CMD_EXTRACT) begin
            if (r_first) r_b0 <= r_addr_ok ? r_rdata : 8'h00;
            else         r_b1 <= r_addr_ok ? r_rdata : 8'h00;
        end
        if (i_cmd.step_byte) begin
            r_bc    <= r_bc + BC_W'(1);
            r_first <= 1'b0;
        end
        if (i_cmd.step_row) begin
            r_row <= r_row + CW'(1);
            r_bc  <= BC_W'(x >> 3);
        end
        if (i_cmd.load_out) begin
            r_o_data    <= ext_data;
            r_o_color   <= r_color;
            r_o_ok      <= r_ok;
            r_o_touched <= r_touched;
        end
    end

    // sweep counter and colour state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_sweep_lim <= SWEEP_FULL;
            r_cc_valid  <= 1'b0;
            r_cc        <= 3'd0;
            r_mixed     <= 1'b0;
            r_touched   <= 1'b0;
        end else begin
            if (i_cmd.sweep && r_sweep_cnt != r_sweep_lim) r_sweep_cnt <= r_sweep_cnt + SW'(1);
            if (i_cmd.dec) begin
                case (r_req.command)
                    CMD_CLEAR: begin
                        if (need_ok) begin
                            r_sweep_cnt <= '0;
                            r_sweep_lim <= need[SW-1:0];
                            r_cc_valid  <= 1'b0;
                            r_mixed     <= 1'b0;
                            r_touched   <= 1'b0;
                        end
                    end
                    CMD_FILL, CMD_BITMAP: begin
                        if (clip_ok) begin
                            r_touched <= 1'b1;
                            if (r_req.command == CMD_FILL && full_black) begin
                                r_cc_valid <= 1'b0;
                                r_mixed    <= 1'b0;
                            end else if (r_req.pixel_color != COLOR_BLACK) begin
                                if (!r_cc_valid) begin
                                    r_cc_valid <= 1'b1;
                                    r_cc       <= r_req.pixel_color;
                                end else if (r_cc != r_req.pixel_color) begin
                                    r_mixed <= 1'b1;
                                end
                            end
                        end
                    end
                    default: r_touched <= r_touched;
                endcase
            end
        end
    end

    // store write port: clearing sweep or merged byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && r_sweep_cnt != r_sweep_lim) begin
            r_store[r_sweep_cnt[AW-1:0]] <= 8'h00;
        end else if (i_cmd.mod && r_req.command != CMD_EXTRACT && r_addr_ok) begin
            r_store[r_addr[AW-1:0]] <= new_byte;
        end
    end

    // store read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= r_store[r_addr[AW-1:0]];
    end

    assign o_data    = r_o_data;
    assign o_color   = r_o_color;
    assign o_ok      = r_o_ok;
    assign o_touched = r_o_touched;

endmodule

>>> hw/rtl/mono_canvas_blitter.sv
// mono_canvas_blitter: top level over mcb_ctrl and mcb_dpath, uses mcb_pkg
// Sequence: each request is captured and decoded; query, clear reject, unknown
// request and clipped-away draws then finish. Bitmap walks one or two bytes,
// extract two, fill each touched byte, by address, read, modify; clear sweeps.
// Throughput: one request at a time on the canvas store.
// Reset: synchronous, active low; a clearing pass over all CANVAS_BYTES follows.
module mono_canvas_blitter #(
    parameter int CANVAS_BYTES = mcb_pkg::CANVAS_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_pos[9:0], y_pos[19:10], rect_width[30:20], rect_height[41:31],
    // pixel_color[44:42], row_index[54:45], byte_index[61:55], source_byte[69:62]
    input  logic [71:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_out[7:0], output_color[10:8], ok[11], touched[12]
    output logic [15:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcb_pkg::*;

    logic [10:0] r_cfg_width, r_cfg_height;
    logic [7:0]  r_cfg_override;
    t_req        req;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;
    logic [7:0]  res_data;
    logic [2:0]  res_color;
    logic        res_ok, res_touched;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= 11'd128;
            r_cfg_height   <= 11'd64;
            r_cfg_override <= 8'd255;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:    r_cfg_width    <= pwdata[10:0];
                REG_HEIGHT:   r_cfg_height   <= pwdata[10:0];
                REG_OVERRIDE: r_cfg_override <= pwdata[7:0];
                default:      r_cfg_override <= r_cfg_override;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:    prdata = {21'd0, r_cfg_width};
            REG_HEIGHT:   prdata = {21'd0, r_cfg_height};
            REG_OVERRIDE: prdata = {24'd0, r_cfg_override};
            default:      prdata = 32'd0;
        endcase
    end

    // request unpacking
    always_comb begin
        req.command     = s_axis_tuser;
        req.x_pos       = s_axis_tdata[9:0];
        req.y_pos       = s_axis_tdata[19:10];
        req.rect_width  = s_axis_tdata[30:20];
        req.rect_height = s_axis_tdata[41:31];
        req.pixel_color = s_axis_tdata[44:42];
        req.row_index   = s_axis_tdata[54:45];
        req.byte_index  = s_axis_tdata[61:55];
        req.source_byte = s_axis_tdata[69:62];
    end

    mcb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    mcb_dpath #(
        .CANVAS_BYTES (CANVAS_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_cfg_width    (r_cfg_width),
        .i_cfg_height   (r_cfg_height),
        .i_cfg_override (r_cfg_override),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_data         (res_data),
        .o_color        (res_color),
        .o_ok           (res_ok),
        .o_touched      (res_touched)
    );

    // result packing
    assign m_axis_tdata = {3'd0, res_touched, res_ok, res_color, res_data};

endmodule
